// ===== rtl/core/ulcd_pkg.sv =====
// shared constants and types for the uart line command decoder
// no dependencies

package ulcd_pkg;

    localparam int LINE_CHARS_DEF = 32;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef logic [3:0] t_kw;

    localparam t_kw KW_START = 4'd0;
    localparam t_kw KW_H     = 4'd1;
    localparam t_kw KW_HE    = 4'd2;
    localparam t_kw KW_HEL   = 4'd3;
    localparam t_kw KW_HELP  = 4'd4;
    localparam t_kw KW_P     = 4'd5;
    localparam t_kw KW_PI    = 4'd6;
    localparam t_kw KW_PIN   = 4'd7;
    localparam t_kw KW_PING  = 4'd8;
    localparam t_kw KW_D     = 4'd9;
    localparam t_kw KW_NONE  = 4'd10;

    typedef logic [1:0] t_resp;

    localparam t_resp RESP_SET     = 2'd0;
    localparam t_resp RESP_HELP    = 2'd1;
    localparam t_resp RESP_PONG    = 2'd2;
    localparam t_resp RESP_INVALID = 2'd3;

    localparam logic [6:0] DISP_MAX = 7'd99;
    localparam logic [6:0] NUM_SAT  = 7'd100;

    typedef struct packed {
        logic       valid;
        t_resp      response;
        logic [6:0] display_value;
    } t_line_result;

endpackage

// ===== rtl/core/ulcd_parser.sv =====
// per-line parse state: keyword tracking, number token and character count
// depends on ulcd_pkg

module ulcd_parser
    import ulcd_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  logic [7:0]   i_byte,
    output t_line_result o_result
);

    localparam int CW = $clog2(LINE_CHARS);
    localparam logic [CW-1:0] LIMIT = CW'(LINE_CHARS - 1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_GAP,
        PH_NUMPRE,
        PH_NUMDIG,
        PH_REST
    } t_phase;

    t_phase        r_phase, n_phase;
    t_kw           r_kw, n_kw;
    logic [CW-1:0] r_count, n_count;
    logic          r_neg, n_neg;
    logic [6:0]    r_value, n_value;
    logic          r_stopped, n_stopped;

    logic          is_digit;
    logic          is_ws;
    logic          numpre;
    logic [10:0]   acc;
    logic [6:0]    dig_value;
    t_kw           kw_step;
    t_kw           kw_cur;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_ws    = (i_byte == CH_TAB) || (i_byte == CH_VT) ||
                      (i_byte == CH_FF) || (i_byte == CH_CR);
    assign acc      = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                      + {3'b000, i_byte - CH_ZERO};
    assign dig_value = (acc >= 11'd100) ? NUM_SAT : acc[6:0];
    assign numpre   = (r_phase == PH_NUMPRE) ||
                      ((r_phase == PH_GAP) && (i_byte != CH_SPACE));
    assign kw_cur   = (r_phase == PH_LEAD) ? KW_START : r_kw;

    always_comb begin
        kw_step = KW_NONE;
        case (kw_cur)
            KW_START: begin
                if (i_byte == "h") kw_step = KW_H;
                else if (i_byte == "p") kw_step = KW_P;
                else if (i_byte == "d") kw_step = KW_D;
            end
            KW_H:   if (i_byte == "e") kw_step = KW_HE;
            KW_HE:  if (i_byte == "l") kw_step = KW_HEL;
            KW_HEL: if (i_byte == "p") kw_step = KW_HELP;
            KW_P:   if (i_byte == "i") kw_step = KW_PI;
            KW_PI:  if (i_byte == "n") kw_step = KW_PIN;
            KW_PIN: if (i_byte == "g") kw_step = KW_PING;
            default: kw_step = KW_NONE;
        endcase
    end

    always_comb begin
        o_result.valid         = 1'b0;
        o_result.response      = RESP_INVALID;
        o_result.display_value = 7'd0;
        case (r_kw)
            KW_HELP: o_result.response = RESP_HELP;
            KW_PING: o_result.response = RESP_PONG;
            KW_D: begin
                o_result.response = RESP_SET;
                if ((r_neg && r_value != 7'd0) || r_value >= NUM_SAT)
                    o_result.display_value = DISP_MAX;
                else
                    o_result.display_value = r_value;
            end
            default: o_result.response = RESP_INVALID;
        endcase
        if (i_take && i_byte == CH_NL)
            o_result.valid = 1'b1;
    end

    always_comb begin
        n_phase   = r_phase;
        n_kw      = r_kw;
        n_count   = r_count;
        n_neg     = r_neg;
        n_value   = r_value;
        n_stopped = r_stopped;
        if (i_take) begin
            if (i_byte == CH_NL) begin
                n_phase   = PH_LEAD;
                n_kw      = KW_START;
                n_count   = '0;
                n_neg     = 1'b0;
                n_value   = 7'd0;
                n_stopped = 1'b0;
            end else if (r_count < LIMIT) begin
                n_count = r_count + 1'b1;
                if (i_byte == CH_NUL) begin
                    n_count = LIMIT;
                end else if (numpre) begin
                    n_phase = PH_NUMPRE;
                    if (is_ws) begin
                        n_phase = PH_NUMPRE;
                    end else if (i_byte == CH_PLUS) begin
                        n_phase = PH_NUMDIG;
                    end else if (i_byte == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_NUMDIG;
                    end else if (is_digit) begin
                        n_value = dig_value;
                        n_phase = PH_NUMDIG;
                    end else begin
                        n_stopped = 1'b1;
                        n_phase   = PH_REST;
                    end
                end else begin
                    case (r_phase)
                        PH_LEAD: begin
                            if (i_byte != CH_SPACE) begin
                                n_kw    = kw_step;
                                n_phase = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            if (i_byte == CH_SPACE)
                                n_phase = (r_kw == KW_D) ? PH_GAP : PH_REST;
                            else
                                n_kw = kw_step;
                        end
                        PH_NUMDIG: begin
                            if (is_digit) begin
                                n_value = dig_value;
                            end else begin
                                n_stopped = 1'b1;
                                n_phase   = PH_REST;
                            end
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEAD;
            r_kw      <= KW_START;
            r_count   <= '0;
            r_neg     <= 1'b0;
            r_value   <= 7'd0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_kw      <= n_kw;
            r_count   <= n_count;
            r_neg     <= n_neg;
            r_value   <= n_value;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ===== rtl/core/uart_line_command_decoder_unit.sv =====
// top level of the uart line command decoder: input and result registers
// depends on ulcd_pkg and ulcd_parser
//
// usage:
//   rx channel: i_rx_valid / o_rx_stall carry one received byte per beat
//   (i_rx_byte); a newline byte closes the current command line.
//   result channel: o_resp_valid / i_resp_stall carry one beat per line
//   with o_response (0 set display, 1 help, 2 pong, 3 invalid) and
//   o_display_value (0..99, zero unless response is set display).
//   throughput: one byte per cycle, every cycle, as long as the result
//   side does not stall.
//   result path: a newline byte goes from the input register through the
//   combinational parser into the result register, which shows its beat;
//   a result-side stall can hold the byte in the input register.
//   stall: while a result beat waits and i_resp_stall is high, no byte is
//   parsed; the input register holds once occupied and raises o_rx_stall.
//   reset: i_rst_n low at a clock edge empties both registers and starts
//   a fresh line with no result pending.
//   only the first LINE_CHARS-1 bytes of a line are parsed.

module uart_line_command_decoder_unit
    import ulcd_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_resp_valid,
    input  logic       i_resp_stall,
    output logic [1:0] o_response,
    output logic [6:0] o_display_value
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    t_resp        r_response;
    logic [6:0]   r_display;
    logic         hold;
    logic         take;
    t_line_result result;

    assign hold       = r_out_valid && i_resp_stall;
    assign take       = r_in_valid && !hold;
    assign o_rx_stall = r_in_valid && hold;

    ulcd_parser #(
        .LINE_CHARS(LINE_CHARS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_rx_stall)
                r_in_valid <= i_rx_valid;
            if (!hold)
                r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid)
            r_in_byte <= i_rx_byte;
        if (!hold && result.valid) begin
            r_response <= result.response;
            r_display  <= result.display_value;
        end
    end

    assign o_resp_valid    = r_out_valid;
    assign o_response      = r_response;
    assign o_display_value = r_display;

endmodule

// ===== rtl/core/ulcd_checker.sv =====
// port-level checks for uart_line_command_decoder_unit, attached by bind
// depends on ulcd_pkg

module ulcd_checker
    import ulcd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_resp_valid,
    input logic       i_resp_stall,
    input logic [1:0] o_response,
    input logic [6:0] o_display_value
);

    a_value_only_for_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_response != RESP_SET |-> o_display_value == 7'd0)
        else $error("display value set on a non-display response");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid |-> o_display_value <= DISP_MAX)
        else $error("display value above 99");

    a_rx_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_resp_valid && i_resp_stall)
        else $error("rx stalled without a blocked result beat");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && i_resp_stall |=>
            o_resp_valid && $stable(o_response) && $stable(o_display_value))
        else $error("stalled result beat changed");

endmodule

bind uart_line_command_decoder_unit ulcd_checker u_ulcd_checker (.*);
